FILE: design/srsw_pkg.sv
// Package for the selective-repeat send window.
// Holds widths, action and status codes, and the controller/datapath command types.
// No dependencies.
package srsw_pkg;

    localparam int MaxWindow = 16;
    localparam int SlotW     = $clog2(MaxWindow);
    localparam int CountW    = $clog2(MaxWindow + 1);

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_ACK     = 3'd1;
    localparam logic [2:0] ACT_TICK    = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_REMOVE  = 3'd4;
    localparam logic [2:0] ACT_ADVANCE = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture input item, reset walk index
        logic              add;       // store new entry at tail
        logic              tick;      // advance the tick clock
        logic              mark_ack;  // set acked on current entry
        logic              restart;   // restart timer on current entry
        logic              pop;       // drop head entry
        logic              step;      // move walk index forward
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic              empty;     // no entries
        logic              full;      // occupancy at limit
        logic              walk_end;  // walk index reached occupancy
        logic              match;     // current entry seq matches
        logic              timed_out; // current entry unacked and expired
        logic              head_acked;
        logic              drop_done; // removed count reached drop target or window empty
    } t_dp_stat;

endpackage

FILE: design/srsw_datapath.sv
// Datapath of the selective-repeat send window: entry storage, pointers and
// walk index. Depends on srsw_pkg.
module srsw_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    input  logic [31:0]             i_seq,
    input  logic [4:0]              i_drop,
    input  srsw_pkg::t_dp_cmd       i_cmd,
    output srsw_pkg::t_dp_stat      o_stat,
    output logic [31:0]             o_cur_seq,
    output logic [4:0]              o_occ,
    output logic                    o_can_add,
    output logic [31:0]             o_head_seq,
    output logic [4:0]              o_removed
);
    import srsw_pkg::*;

    logic [31:0]        r_seq_mem  [MaxWindow];
    logic [31:0]        r_time_mem [MaxWindow];
    logic [MaxWindow-1:0] r_acked;
    logic [SlotW-1:0]   r_head;
    logic [CountW-1:0]  r_count;
    logic [31:0]        r_clock;
    logic [4:0]         r_win;
    logic [15:0]        r_timeout;
    logic [31:0]        r_key;
    logic [4:0]         r_drop;
    logic [CountW-1:0]  r_idx;
    logic [4:0]         r_removed;

    logic [SlotW-1:0]   w_slot;
    logic [SlotW-1:0]   w_tail;
    logic [31:0]        w_age;
    logic [4:0]         w_limit;

    assign w_slot  = r_head + r_idx[SlotW-1:0];
    assign w_tail  = r_head + r_count[SlotW-1:0];
    assign w_age   = r_clock - r_time_mem[w_slot];
    assign w_limit = (r_win < 5'(MaxWindow)) ? r_win : 5'(MaxWindow);

    // status toward controller
    always_comb begin
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (5'(r_count) >= w_limit);
        o_stat.walk_end   = (r_idx >= r_count);
        o_stat.match      = (r_seq_mem[w_slot] == r_key);
        o_stat.timed_out  = !r_acked[w_slot] && (w_age > {16'd0, r_timeout});
        o_stat.head_acked = r_acked[r_head];
        o_stat.drop_done  = (r_removed >= r_drop) || (r_count == '0);
    end

    assign o_cur_seq  = r_seq_mem[w_slot];
    assign o_occ      = 5'(r_count);
    assign o_can_add  = (5'(r_count) < w_limit);
    assign o_head_seq = (r_count != '0) ? r_seq_mem[r_head] : 32'd0;
    assign o_removed  = r_removed;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked   <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_clock   <= '0;
            r_win     <= 5'd16;
            r_timeout <= 16'd500;
            r_idx     <= '0;
            r_removed <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WINDOW_SIZE) r_win <= i_cfg_data[4:0];
                else                              r_timeout <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_removed <= '0;
            end
            if (i_cmd.step) r_idx <= r_idx + 1'b1;
            if (i_cmd.tick) r_clock <= r_clock + 32'd1;
            if (i_cmd.add) begin
                r_acked[w_tail] <= 1'b0;
                r_count         <= r_count + 1'b1;
            end
            if (i_cmd.mark_ack) r_acked[w_slot] <= 1'b1;
            if (i_cmd.pop) begin
                r_acked[r_head] <= 1'b0;
                r_head          <= r_head + 1'b1;
                r_count         <= r_count - 1'b1;
                r_removed       <= r_removed + 5'd1;
            end
        end
    end

    // entry storage and captured operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_seq;
            r_drop <= i_drop;
        end
        if (i_cmd.add) begin
            r_seq_mem[w_tail]  <= r_key;
            r_time_mem[w_tail] <= r_clock;
        end
        if (i_cmd.restart) r_time_mem[w_slot] <= r_clock;
    end

    // occupancy never exceeds the array depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MaxWindow)) else $error("occupancy over depth");
    // pop only on a non-empty window
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0) else $error("pop on empty window");
    // add only when below limit
    a_add_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |-> o_can_add) else $error("add on full window");
endmodule

FILE: design/srsw_ctrl.sv
// Controller of the selective-repeat send window: sequences each action and
// drives the result register. Depends on srsw_pkg.
module srsw_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_action,
    input  srsw_pkg::t_dp_stat      i_stat,
    output srsw_pkg::t_dp_cmd       o_cmd,
    input  logic [31:0]             i_cur_seq,
    input  logic [4:0]              i_occ,
    input  logic                    i_can_add,
    input  logic [31:0]             i_head_seq,
    input  logic [4:0]              i_removed,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [31:0]             o_to_seq,
    output logic                    o_to_valid,
    output logic [4:0]              o_removed,
    output logic [4:0]              o_occ,
    output logic                    o_can_add,
    output logic                    o_has,
    output logic [31:0]             o_head_seq,
    output logic                    o_last
);
    import srsw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_WALK, S_EMIT, S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_act;
    logic        r_found;
    logic        r_any;
    logic        r_ovalid;
    logic        r_olast;
    logic [1:0]  r_status;
    logic [31:0] r_to_seq;
    logic        r_to_valid;
    logic [31:0] r_pend_seq;
    logic        w_out_free;
    logic        w_hit;
    logic        w_emit;
    logic        w_final;

    // one result register; the tick scan pauses while it is held
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // timed-out entry found during the tick scan
    assign w_hit   = (r_state == S_WALK) && (r_act == ACT_TICK) && !i_stat.walk_end
                     && i_stat.timed_out && w_out_free;
    // a held-back timed-out entry goes out when the next one is found
    assign w_emit  = w_hit && r_any;
    assign w_final = (r_state == S_DONE) && w_out_free;

    // command decode
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_act == ACT_TICK) o_cmd.tick = 1'b1;
                if (r_act == ACT_ADD && !i_stat.full) o_cmd.add = 1'b1;
                if (r_act == ACT_ADD || r_act > ACT_ADVANCE || i_stat.empty)
                    n_state = (r_act == ACT_TICK) ? S_WALK : S_DONE;
                else n_state = S_WALK;
            end
            S_WALK: begin
                case (r_act)
                    ACT_ACK: begin
                        if (i_stat.walk_end) n_state = S_DONE;
                        else if (i_stat.match) begin
                            o_cmd.mark_ack = 1'b1;
                            n_state = S_DONE;
                        end else o_cmd.step = 1'b1;
                    end
                    ACT_RESTART: begin
                        if (i_stat.walk_end) n_state = S_DONE;
                        else begin
                            o_cmd.restart = i_stat.match;
                            o_cmd.step = 1'b1;
                        end
                    end
                    ACT_REMOVE: begin
                        if (i_stat.drop_done) n_state = S_DONE;
                        else o_cmd.pop = 1'b1;
                    end
                    ACT_ADVANCE: begin
                        if (i_stat.empty || !i_stat.head_acked) n_state = S_DONE;
                        else o_cmd.pop = 1'b1;
                    end
                    default: begin
                        // tick scan
                        if (i_stat.walk_end) n_state = S_DONE;
                        else if (!i_stat.timed_out) o_cmd.step = 1'b1;
                        else if (w_out_free) begin
                            o_cmd.step = 1'b1;
                            n_state = S_EMIT;
                        end
                    end
                endcase
            end
            S_EMIT: n_state = S_WALK;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state, per-item flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_act    <= '0;
            r_found  <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit || w_final) r_ovalid <= 1'b1;
            else if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (o_cmd.load) begin
                r_act   <= i_action;
                r_found <= 1'b0;
                r_any   <= 1'b0;
            end
            if (o_cmd.mark_ack || o_cmd.restart) r_found <= 1'b1;
            if (r_state == S_DISPATCH) begin
                r_status <= (r_act == ACT_ADD && i_stat.full) ? ST_FULL :
                            ((r_act == ACT_ACK || r_act == ACT_RESTART
                              || r_act == ACT_REMOVE || r_act == ACT_ADVANCE)
                             && i_stat.empty) ? ST_EMPTY : ST_OK;
            end
            // timed-out entry: held back until the next one or the end of the scan
            if (w_hit) begin
                r_pend_seq <= i_cur_seq;
                r_any      <= 1'b1;
            end
            if (w_emit) begin
                r_olast    <= 1'b0;
                r_to_seq   <= r_pend_seq;
                r_to_valid <= 1'b1;
            end
            // final result: in tick mode the last timed-out entry carries last
            if (w_final) begin
                r_olast    <= 1'b1;
                r_to_seq   <= r_any ? r_pend_seq : 32'd0;
                r_to_valid <= r_any;
            end
        end
    end

    // final fields are latched in walk or done while the result register is free
    logic [1:0]  r_fstatus;
    logic [4:0]  r_frem;
    logic [4:0]  r_focc;
    logic        r_fcan;
    logic [31:0] r_fhead;
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE || r_state == S_WALK) && w_out_free) begin
            r_fstatus <= (r_status == ST_OK && (r_act == ACT_ACK || r_act == ACT_RESTART)
                          && !r_found) ? ST_NOT_FOUND : r_status;
            r_frem    <= (r_act == ACT_REMOVE || r_act == ACT_ADVANCE) ? i_removed : 5'd0;
            r_focc    <= i_occ;
            r_fcan    <= i_can_add;
            r_fhead   <= i_head_seq;
        end
    end

    assign o_status   = r_olast ? r_fstatus : ST_OK;
    assign o_to_seq   = r_to_seq;
    assign o_to_valid = r_to_valid;
    assign o_removed  = r_olast ? r_frem : 5'd0;
    assign o_occ      = r_focc;
    assign o_can_add  = r_fcan;
    assign o_has      = (r_focc != 5'd0);
    assign o_head_seq = r_fhead;
    assign o_last     = r_olast;

    // input taken only between items
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    // result register not overwritten while held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> r_ovalid) else $error("result lost");
    // at most one of add, mark_ack, pop and tick per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.add, o_cmd.mark_ack, o_cmd.pop, o_cmd.tick}))
        else $error("conflicting commands");
endmodule

FILE: design/selective_repeat_send_window.sv
// Top level of the selective-repeat send window: streaming ports, controller
// and datapath. Depends on srsw_pkg, srsw_ctrl, srsw_datapath.
//
// Channel   Dir  Fields (tdata low bit up)
// s_axis    in   action[2:0], seq_num[34:3], drop_count[39:35]
// m_axis    out  status, timed_out_seq, timed_out_valid, removed_count,
//                occupancy, can_add, has_entries, head_seq; tlast = last
// cfg       in   index 0 window_size, 1 timeout_ticks
//
// One item at a time: ack, restart, remove, advance and tick walk the entry FIFO
// one entry per cycle; tick also passes through an emit state per timed-out entry.
// A stalled m_axis holds the tick scan and the final result. Reset is synchronous,
// active low; the window starts empty.
module selective_repeat_send_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action, seq_num, drop_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, timed_out_seq, timed_out_valid, removed_count, occupancy,
    // can_add, has_entries, head_seq, 1 pad bit
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import srsw_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic [31:0] w_cur_seq, w_head_dp, w_to_seq, w_head;
    logic [4:0]  w_occ_dp, w_rem_dp, w_rem, w_occ;
    logic        w_can_dp, w_to_valid, w_can, w_has;
    logic [1:0]  w_status;

    srsw_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_seq(s_axis_tdata[34:3]), .i_drop(s_axis_tdata[39:35]),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_cur_seq(w_cur_seq),
        .o_occ(w_occ_dp), .o_can_add(w_can_dp), .o_head_seq(w_head_dp),
        .o_removed(w_rem_dp)
    );

    srsw_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(s_axis_tdata[2:0]), .i_stat(w_stat), .o_cmd(w_cmd),
        .i_cur_seq(w_cur_seq), .i_occ(w_occ_dp), .i_can_add(w_can_dp),
        .i_head_seq(w_head_dp), .i_removed(w_rem_dp),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_status(w_status), .o_to_seq(w_to_seq), .o_to_valid(w_to_valid),
        .o_removed(w_rem), .o_occ(w_occ), .o_can_add(w_can), .o_has(w_has),
        .o_head_seq(w_head), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_head, w_has, w_can, w_occ, w_rem,
                           w_to_valid, w_to_seq, w_status};
endmodule

FILE: test/selective_repeat_send_window_tb.sv
// Testbench for the selective-repeat send window: directed and random items on the
// stream ports, results checked against an in-bench window model.
// Depends on srsw_pkg and selective_repeat_send_window.
`timescale 1ns / 100ps

module selective_repeat_send_window_tb;
    import srsw_pkg::*;

    // laid out to match {tdata[78:0], tlast}
    typedef struct packed {
        logic [31:0] head_seq;
        logic        has_entries;
        logic        can_add;
        logic [4:0]  occupancy;
        logic [4:0]  removed;
        logic        to_valid;
        logic [31:0] to_seq;
        logic [1:0]  status;
        logic        last;
    } win_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // action, seq_num, drop_count
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // status, timed_out_seq, timed_out_valid, removed_count, occupancy,
    // can_add, has_entries, head_seq, pad
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_data = '0;

    selective_repeat_send_window dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // window model state
    logic [31:0] win_seq [MaxWindow];
    logic [31:0] win_sent [MaxWindow];
    logic        win_acked [MaxWindow];
    int unsigned win_head = 0;
    int unsigned win_count = 0;
    logic [31:0] win_clock = '0;
    int unsigned win_size = 16;
    logic [15:0] win_timeout = 16'd500;

    // ring of expected results
    localparam int ExpDepth = 64;
    win_result_t exp_buf [ExpDepth];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;
    int          fail_count = 0;
    int          send_gap_max = 18;
    int          recv_stall_max = 18;
    int          recv_stall_left = 0;
    int unsigned next_seq = 32'd100;

    function automatic int unsigned win_limit();
        return (win_size < MaxWindow) ? win_size : MaxWindow;
    endfunction

    function automatic void push_result(logic [1:0] st, logic [31:0] tseq, logic tv,
                                        logic [4:0] rem, logic lst);
        win_result_t r;
        r.status      = st;
        r.to_seq      = tseq;
        r.to_valid    = tv;
        r.removed     = rem;
        r.occupancy   = win_count[4:0];
        r.can_add     = win_count < win_limit();
        r.has_entries = win_count != 0;
        r.head_seq    = (win_count != 0) ? win_seq[win_head] : 32'd0;
        r.last        = lst;
        exp_buf[exp_wr % ExpDepth] = r;
        exp_wr++;
    endfunction

    function automatic void pop_head();
        win_acked[win_head] = 1'b0;
        win_head = (win_head + 1) % MaxWindow;
        win_count--;
    endfunction

    // expected results of one accepted item
    function automatic void predict_window(logic [2:0] act, logic [31:0] seq,
                                           logic [4:0] drop);
        logic [1:0]  st;
        int unsigned rem;
        int unsigned s;
        int          hits;
        st = ST_OK;
        rem = 0;
        hits = 0;
        case (act)
            ACT_ADD: begin
                if (win_count >= win_limit()) st = ST_FULL;
                else begin
                    s = (win_head + win_count) % MaxWindow;
                    win_seq[s] = seq;
                    win_sent[s] = win_clock;
                    win_acked[s] = 1'b0;
                    win_count++;
                end
            end
            ACT_ACK, ACT_RESTART: begin
                if (win_count == 0) st = ST_EMPTY;
                else begin
                    st = ST_NOT_FOUND;
                    for (int i = 0; i < win_count; i++) begin
                        s = (win_head + i) % MaxWindow;
                        if (win_seq[s] == seq && !(act == ACT_ACK && st == ST_OK)) begin
                            if (act == ACT_ACK) win_acked[s] = 1'b1;
                            else win_sent[s] = win_clock;
                            st = ST_OK;
                        end
                    end
                end
            end
            ACT_TICK: begin
                win_clock = win_clock + 32'd1;
                for (int i = 0; i < win_count; i++) begin
                    s = (win_head + i) % MaxWindow;
                    if (!win_acked[s] && (win_clock - win_sent[s]) > {16'd0, win_timeout}) begin
                        push_result(ST_OK, win_seq[s], 1'b1, 5'd0, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0) push_result(ST_OK, 32'd0, 1'b0, 5'd0, 1'b1);
                else exp_buf[(exp_wr - 1) % ExpDepth].last = 1'b1;
                return;
            end
            ACT_REMOVE: begin
                if (win_count == 0) st = ST_EMPTY;
                else begin
                    rem = (drop < win_count) ? drop : win_count;
                    for (int i = 0; i < rem; i++) pop_head();
                end
            end
            ACT_ADVANCE: begin
                if (win_count == 0) st = ST_EMPTY;
                else while (win_count != 0 && win_acked[win_head]) begin
                    pop_head();
                    rem++;
                end
            end
            default: ;
        endcase
        push_result(st, 32'd0, 1'b0, rem[4:0], 1'b1);
    endfunction

    // send one item; valid stays high into the next call when no gap is drawn
    task automatic send_item(logic [2:0] act, logic [31:0] seq, logic [4:0] drop);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {drop, seq, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_window(act, seq, drop);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW_SIZE) win_size = value[4:0];
        else win_timeout = value;
    endtask

    // receiver: stall count is drawn after each accepted result
    always @(negedge i_clk) begin
        if (recv_stall_left > 0) begin
            recv_stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        win_result_t got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[78:0], m_axis_tlast};
            recv_stall_left = $urandom_range(0, recv_stall_max);
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result %h", $realtime, got);
                fail_count++;
            end else begin
                exp_r = exp_buf[exp_rd % ExpDepth];
                exp_rd++;
                if (got.status !== exp_r.status)
                    $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
                if (got.to_seq !== exp_r.to_seq)
                    $display("%0t: timed_out_seq exp %h got %h", $realtime, exp_r.to_seq,
                             got.to_seq);
                if (got.to_valid !== exp_r.to_valid)
                    $display("%0t: timed_out_valid exp %0d got %0d", $realtime,
                             exp_r.to_valid, got.to_valid);
                if (got.removed !== exp_r.removed)
                    $display("%0t: removed exp %0d got %0d", $realtime, exp_r.removed,
                             got.removed);
                if (got.occupancy !== exp_r.occupancy)
                    $display("%0t: occupancy exp %0d got %0d", $realtime, exp_r.occupancy,
                             got.occupancy);
                if (got.can_add !== exp_r.can_add)
                    $display("%0t: can_add exp %0d got %0d", $realtime, exp_r.can_add,
                             got.can_add);
                if (got.has_entries !== exp_r.has_entries)
                    $display("%0t: has_entries exp %0d got %0d", $realtime,
                             exp_r.has_entries, got.has_entries);
                if (got.head_seq !== exp_r.head_seq)
                    $display("%0t: head_seq exp %h got %h", $realtime, exp_r.head_seq,
                             got.head_seq);
                if (got.last !== exp_r.last)
                    $display("%0t: last exp %0d got %0d", $realtime, exp_r.last, got.last);
                if (got !== exp_r) fail_count++;
            end
        end
    end

    // empty window: every action but add, unknown codes, extreme seq values
    task automatic test_empty_window();
        send_item(ACT_ACK, 32'hFFFF_FFFF, 5'd0);
        send_item(ACT_RESTART, 32'd0, 5'd0);
        send_item(ACT_REMOVE, 32'd0, 5'd31);
        send_item(ACT_ADVANCE, 32'd0, 5'd0);
        send_item(ACT_TICK, 32'd0, 5'd0);
        send_item(3'd6, 32'hFFFF_FFFF, 5'd31);
        send_item(3'd7, 32'h0, 5'd0);
    endtask

    // fill to the limit, refuse one more, ack/advance/remove
    task automatic test_fill_and_drain();
        for (int i = 0; i < 16; i++) send_item(ACT_ADD, (i == 0) ? 32'hFFFF_FFFF : i, 5'd0);
        send_item(ACT_ADD, 32'd99, 5'd0);
        send_item(ACT_ACK, 32'd1, 5'd0);
        send_item(ACT_ACK, 32'hFFFF_FFFF, 5'd0);
        send_item(ACT_ACK, 32'd12345, 5'd0);
        send_item(ACT_ADVANCE, 32'd0, 5'd0);
        send_item(ACT_REMOVE, 32'd0, 5'd3);
        send_item(ACT_REMOVE, 32'd0, 5'd16);
    endtask

    // short timeout: ticks report every unacked entry, restart hides the restarted ones from the tick after it
    task automatic test_timeouts();
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_WINDOW_SIZE, 16'd16);
        send_item(ACT_ADD, 32'd7, 5'd0);
        send_item(ACT_ADD, 32'd7, 5'd0);
        send_item(ACT_ADD, 32'd8, 5'd0);
        send_item(ACT_TICK, 32'd0, 5'd0);
        send_item(ACT_TICK, 32'd0, 5'd0);
        send_item(ACT_RESTART, 32'd7, 5'd0);
        send_item(ACT_RESTART, 32'd55, 5'd0);
        send_item(ACT_TICK, 32'd0, 5'd0);
        send_item(ACT_TICK, 32'd0, 5'd0);
        // hold off until the window has answered everything
        wait_drained();
        send_item(ACT_REMOVE, 32'd0, 5'd31);
        wait_drained();
    endtask

    task automatic random_phase(int n_items, int ws, int tmo, int idle);
        logic [2:0]  act;
        logic [31:0] seq;
        logic [4:0]  drop;
        int          pick;
        write_reg(REG_WINDOW_SIZE, ws[15:0]);
        write_reg(REG_TIMEOUT, tmo[15:0]);
        send_gap_max = idle;
        recv_stall_max = idle;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            act = (pick < 30) ? ACT_ADD : (pick < 50) ? ACT_ACK : (pick < 70) ? ACT_TICK :
                  (pick < 78) ? ACT_RESTART : (pick < 86) ? ACT_REMOVE :
                  (pick < 97) ? ACT_ADVANCE : 3'($urandom_range(6, 7));
            seq = $urandom;
            if (act == ACT_ADD && $urandom_range(0, 4) != 0) seq = next_seq++;
            if ((act == ACT_ACK || act == ACT_RESTART) && win_count != 0 &&
                $urandom_range(0, 4) != 0)
                seq = win_seq[(win_head + $urandom_range(0, win_count - 1)) % MaxWindow];
            drop = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                   5'($urandom_range(0, 4));
            send_item(act, seq, drop);
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_window();
        test_fill_and_drain();
        wait_drained();
        test_timeouts();
        random_phase(90, 16, 3, 18);
        random_phase(60, 1, 1, 0);
        random_phase(80, 5, 65535, 6);
        random_phase(80, 9, 2, 18);
        random_phase(30, 16, 500, 3);
        if (fail_count == 0) begin
            $display("selective_repeat_send_window_tb OK");
        end else begin
            $display("selective_repeat_send_window_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("selective_repeat_send_window_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
design/srsw_pkg.sv
design/srsw_datapath.sv
design/srsw_ctrl.sv
design/selective_repeat_send_window.sv
test/selective_repeat_send_window_tb.sv
